// ===== rtl/slt_pkg.sv =====
package slt_pkg;

  // Command codes; the codes above CMD_CLEAR do nothing.
  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_DELVAL = 3'd1;
  localparam logic [2:0] CMD_DELIDX = 3'd2;
  localparam logic [2:0] CMD_READ   = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // Width of the key field at the ports.
  localparam int KEY_PORT_BITS = 16;

  // What every cell of the chain does on a clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT_GE,
    CELL_SHIFT_POS
  } cell_op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT
  } state_t;

  // One result word.
  typedef struct packed {
    logic [1:0]               status;
    logic [7:0]               count;
    logic [7:0]               removed;
    logic [KEY_PORT_BITS-1:0] read_key;
  } result_t;

endpackage

// ===== rtl/sorted_list_table_unit.sv =====
// A word is accepted in the idle state and captured; in the execute state its result is
// registered on the output if the output slot is free, else it is held in the wait state.
// Delete by value stays in the execute state for each matching entry it removes.
// A new word is accepted only in the idle state, once the last word's result is registered.
// Reset clears the entry count and the handshake state; stored keys are not cleared.
module sorted_list_table_unit #(
  parameter int CAPACITY = 128,
  parameter int KEY_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         command,
  input  logic [slt_pkg::KEY_PORT_BITS-1:0]  key,
  input  logic [6:0]                         position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         status,
  output logic [7:0]                         count,
  output logic [7:0]                         removed,
  output logic [slt_pkg::KEY_PORT_BITS-1:0]  read_key
);
  import slt_pkg::*;

  localparam int KW = (KEY_BITS < KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 7) ? CW : 7;
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  state_t state, state_next;

  logic [2:0]    cmd_q;
  logic [KW-1:0] key_q;
  logic [PW-1:0] pos_q;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] rem, rem_next;
  result_t       res, res_now;

  cell_op_t      op;
  logic [PW-1:0] bpos;
  logic          finish;
  logic          slot_free;
  logic          accept;

  logic [KW-1:0] cell_key [CAPACITY];
  logic [KW-1:0] cell_sel [CAPACITY];
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic          any_eq;
  logic [KW-1:0] read_bus;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // The chain of cells: each cell talks only to its neighbors and the broadcast.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic          p_lt;
    logic [KW-1:0] p_key;
    logic [KW-1:0] n_key;

    if (i == 0) begin : g_first
      assign p_lt  = 1'b1;
      assign p_key = '0;
    end else begin : g_mid
      assign p_lt  = lt_vec[i-1];
      assign p_key = cell_key[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign n_key = '0;
    end else begin : g_inner
      assign n_key = cell_key[i+1];
    end

    slt_cell #(
      .KW (KW),
      .CW (CW),
      .PW (PW),
      .IDX(i)
    ) u_cell (
      .clk     (clk),
      .op      (op),
      .bkey    (key_q),
      .bpos    (bpos),
      .cnt     (cnt),
      .prev_lt (p_lt),
      .prev_key(p_key),
      .next_key(n_key),
      .key     (cell_key[i]),
      .lt      (lt_vec[i]),
      .eq      (eq_vec[i]),
      .sel_key (cell_sel[i])
    );
  end

  assign any_eq = |eq_vec;

  // Read bus: only the addressed cell drives a nonzero key.
  always_comb begin
    read_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      read_bus = read_bus | cell_sel[i];
    end
  end

  // Command execution and next state.
  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    rem_next         = rem;
    op               = CELL_HOLD;
    bpos             = pos_q;
    finish           = 1'b0;
    res_now          = '0;
    res_now.status   = ST_OK;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        finish = 1'b1;
        case (cmd_q)
          CMD_INSERT: begin
            if (cnt == FULL_COUNT) begin
              res_now.status = ST_FULL;
            end else begin
              op       = CELL_INSERT;
              cnt_next = cnt + 1'b1;
            end
          end
          CMD_DELVAL: begin
            // The table counts as empty only if this command has removed nothing yet.
            if (cnt == '0 && rem == '0) begin
              res_now.status = ST_EMPTY;
            end else if (any_eq) begin
              op       = CELL_SHIFT_GE;
              cnt_next = cnt - 1'b1;
              rem_next = rem + 1'b1;
              finish   = 1'b0;
            end else if (rem == '0) begin
              res_now.status = ST_NOTFOUND;
            end
          end
          CMD_DELIDX: begin
            if (cnt == '0) begin
              res_now.status = ST_EMPTY;
            end else begin
              op       = CELL_SHIFT_POS;
              bpos     = (pos_q >= PW'(cnt)) ? PW'(cnt - 1'b1) : pos_q;
              cnt_next = cnt - 1'b1;
              rem_next = CW'(1);
            end
          end
          CMD_READ: begin
            if (cnt == '0) begin
              res_now.status = ST_EMPTY;
            end else if (pos_q >= PW'(cnt)) begin
              res_now.status = ST_NOTFOUND;
            end else begin
              res_now.read_key[KW-1:0] = read_bus;
            end
          end
          CMD_CLEAR: begin
            rem_next = cnt;
            cnt_next = '0;
          end
          default: begin
            cnt_next = cnt;
          end
        endcase
        res_now.count   = 8'(cnt_next);
        res_now.removed = 8'(rem_next);
        if (finish) begin
          state_next = slot_free ? S_IDLE : S_WAIT;
        end
      end
      S_WAIT: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        rem <= '0;
      end else if (state == S_EXEC) begin
        rem <= rem_next;
      end
      if (state == S_EXEC) begin
        cnt <= cnt_next;
      end
      if ((state == S_EXEC && finish && slot_free) || (state == S_WAIT && slot_free)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Command capture and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= command;
      key_q <= key[KW-1:0];
      pos_q <= PW'(position);
    end
    if (state == S_EXEC && finish) begin
      res <= res_now;
    end
    if (state == S_EXEC && finish && slot_free) begin
      {status, count, removed, read_key} <= res_now;
    end else if (state == S_WAIT && slot_free) begin
      {status, count, removed, read_key} <= res;
    end
  end

  // The entry count never passes the table size.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= FULL_COUNT)
    else $error("entry count above capacity");

  // A finished result waits only while the output register is still occupied.
  a_wait_full: assert property (@(posedge clk) disable iff (rst)
    state == S_WAIT |-> out_valid)
    else $error("result held with an empty output register");

  // Each step of delete by value removes exactly one entry.
  a_delval_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && cmd_q == CMD_DELVAL && cnt != '0 && any_eq)
      |=> (cnt == $past(cnt) - 1'b1) && (state == S_EXEC))
    else $error("delete by value step lost count");

  // Reset leaves an empty table.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> (cnt == '0 && !out_valid))
    else $error("table not empty after reset");

endmodule

// ===== rtl/slt_cell.sv =====
module slt_cell #(
  parameter int KW  = 16,
  parameter int CW  = 8,
  parameter int PW  = 8,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  slt_pkg::cell_op_t op,
  input  logic [KW-1:0]     bkey,
  input  logic [PW-1:0]     bpos,
  input  logic [CW-1:0]     cnt,
  input  logic              prev_lt,
  input  logic [KW-1:0]     prev_key,
  input  logic [KW-1:0]     next_key,
  output logic [KW-1:0]     key,
  output logic              lt,
  output logic              eq,
  output logic [KW-1:0]     sel_key
);
  import slt_pkg::*;

  localparam logic [PW-1:0] MY_POS = PW'(IDX);

  logic occupied;
  logic at_or_after;

  // Local compares against the broadcast key and position.
  always_comb begin
    occupied    = PW'(cnt) > MY_POS;
    lt          = occupied && (key < bkey);
    eq          = occupied && (key == bkey);
    at_or_after = MY_POS >= bpos;
    sel_key     = (MY_POS == bpos) ? key : '0;
  end

  // The stored key moves right on insert and left on removal.
  always_ff @(posedge clk) begin
    case (op)
      CELL_INSERT: begin
        if (!lt) begin
          key <= prev_lt ? bkey : prev_key;
        end
      end
      CELL_SHIFT_GE: begin
        if (!lt) begin
          key <= next_key;
        end
      end
      CELL_SHIFT_POS: begin
        if (at_or_after) begin
          key <= next_key;
        end
      end
      default: begin
        key <= key;
      end
    endcase
  end

endmodule
